@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the orbit camera block.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ocp_pkg.sv @@
// Package for the orbit camera block: field widths, shared types,
// register indexes, CORDIC constants and the arctangent table. No dependencies.
package ocp_pkg;

    // Field and register widths
    localparam int DELTA_W    = 16;
    localparam int POS_W      = 17;
    localparam int SENS_W     = 10;
    localparam int RADIUS_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int TRIG_W     = 32;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int BASE_W     = 34;
    localparam int ACC_W      = 34;
    localparam int TAB_LEN    = 24;
    localparam int TAB_IDX_W  = 5;
    localparam int ANG_SHIFT  = 20;

    typedef logic signed [DELTA_W-1:0]  t_delta;
    typedef logic signed [POS_W-1:0]    t_pos;
    typedef logic        [SENS_W-1:0]   t_sens;
    typedef logic        [RADIUS_W-1:0] t_radius;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic signed [TRIG_W-1:0]   t_trig;
    typedef logic signed [MUL_A_W-1:0]  t_mul_a;
    typedef logic signed [MUL_B_W-1:0]  t_mul_b;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [BASE_W-1:0]   t_base;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // Register indexes
    localparam t_cfg_idx CFG_SENSITIVITY  = 8'd0;
    localparam t_cfg_idx CFG_ORBIT_RADIUS = 8'd1;

    // Register reset values
    localparam t_sens   SENS_RESET   = 10'd90;
    localparam t_radius RADIUS_RESET = 16'd2880;

    // CORDIC gain in Q30 and angle limits in 2^-20 degree
    localparam t_trig CORDIC_K    = 32'sd652032874;
    localparam t_trig ANG_FULL    = 32'sd377487360;
    localparam t_trig ANG_HALF    = 32'sd188743680;
    localparam t_trig ANG_QUARTER = 32'sd94371840;

    // atan(2^-i) in 2^-20 degree
    localparam t_trig ATAN_TAB [TAB_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

endpackage

@@ rtl/ocp_if.sv @@
// Channel interfaces of the orbit camera block: input deltas, result
// positions and register writes. Depends on ocp_pkg.
interface ocp_in_if;
    import ocp_pkg::*;
    logic   valid;
    logic   ready;
    t_delta delta_azimuth;
    t_delta delta_elevation;
    modport source (output valid, delta_azimuth, delta_elevation, input ready);
    modport sink   (input valid, delta_azimuth, delta_elevation, output ready);
endinterface

interface ocp_out_if;
    import ocp_pkg::*;
    logic valid;
    logic ready;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ocp_cfg_if;
    import ocp_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/orbit_camera_position.sv @@
// Orbit camera position: accumulates scaled angle deltas, emits x/y/z on a sphere.
// Each item runs one CORDIC stage for azimuth then elevation, plus a 32x18 multiplier used
// 8 times. A new item is taken only once the last result is handed to the output register;
// a finished result waits in the output register while the next item is worked. Sync
// active-low reset restores sens 90, radius 180.0, azimuth 35 deg, elevation 40 deg.
// Needs ocp_pkg, ocp_if, assert_macros.svh.
`include "assert_macros.svh"

module orbit_camera_position #(
    parameter int FRAC_BITS       = 7,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ocp_in_if.sink           i_in,
    ocp_out_if.source        o_out,
    ocp_cfg_if.sink          i_cfg
);
    import ocp_pkg::*;

    // Angle ranges and widths
    localparam int LIM_AZ = 360 << FRAC_BITS;
    localparam int LIM_EL = (899 << FRAC_BITS) / 10;
    localparam int AZ_W   = $clog2(LIM_AZ + 1) + 1;
    localparam int EL_W   = $clog2(LIM_EL + 1) + 1;
    localparam int SC_W   = 19;
    localparam int WIDE_W = ((AZ_W > SC_W) ? AZ_W : SC_W) + 2;
    localparam int IT_W   = $clog2(TRIG_ITERATIONS);
    localparam int ZSH    = ANG_SHIFT - FRAC_BITS;
    localparam int SPLIT  = MUL_B_W - 1;

    typedef logic signed [AZ_W-1:0]   t_az;
    typedef logic signed [EL_W-1:0]   t_el;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic        [IT_W-1:0]   t_iter;

    localparam t_wide LIM_AZ_W = t_wide'(LIM_AZ);
    localparam t_wide LIM_EL_W = t_wide'(LIM_EL);
    localparam t_az   AZ_RESET = t_az'(35 << FRAC_BITS);
    localparam t_el   EL_RESET = t_el'(40 << FRAC_BITS);
    localparam t_iter IT_LAST  = t_iter'(TRIG_ITERATIONS - 1);

    localparam t_prod RND8  = t_prod'(128);
    localparam t_prod RND14 = t_prod'(1) << 13;
    localparam t_prod RND30 = t_prod'(1) << 29;
    localparam t_prod RND45 = t_prod'(1) << 45;
    localparam t_prod OUT_HI = t_prod'(65535);
    localparam t_prod OUT_LO = -t_prod'(65535);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_MUL_A  = 15'h0002,
        S_MUL_E  = 15'h0004,
        S_UPD_E  = 15'h0008,
        S_WRAP   = 15'h0010,
        S_FOLD   = 15'h0020,
        S_ITER   = 15'h0040,
        S_MUL_B  = 15'h0080,
        S_MUL_Y  = 15'h0100,
        S_MUL_XL = 15'h0200,
        S_MUL_XH = 15'h0400,
        S_MUL_ZL = 15'h0800,
        S_MUL_ZH = 15'h1000,
        S_FIN_Z  = 15'h2000,
        S_DONE   = 15'h4000
    } t_state;

    // Clamp a wide result to the Q12.4 output range
    function automatic t_pos sat_pos(input t_prod v);
        if (v > OUT_HI) begin
            return t_pos'(OUT_HI);
        end else if (v < OUT_LO) begin
            return t_pos'(OUT_LO);
        end
        return t_pos'(v);
    endfunction

    // Control registers
    t_state  r_state,     n_state;
    t_sens   r_sens,      n_sens;
    t_radius r_radius,    n_radius;
    t_az     r_az,        n_az;
    t_el     r_el,        n_el;
    logic    r_out_valid, n_out_valid;
    logic    r_sel_el,    n_sel_el;
    t_iter   r_iter,      n_iter;

    // Payload registers
    t_delta  r_din_a,  n_din_a;
    t_delta  r_din_e,  n_din_e;
    t_trig   r_x,      n_x;
    t_trig   r_y,      n_y;
    t_trig   r_z,      n_z;
    logic    r_neg,    n_neg;
    t_trig   r_sa,     n_sa;
    t_trig   r_ca,     n_ca;
    t_trig   r_se,     n_se;
    t_trig   r_ce,     n_ce;
    t_prod   r_prod;
    t_base   r_base,   n_base;
    t_acc    r_acc,    n_acc;
    t_pos    r_px,     n_px;
    t_pos    r_py,     n_py;
    t_pos    r_pz,     n_pz;
    t_pos    r_out_x,  n_out_x;
    t_pos    r_out_y,  n_out_y;
    t_pos    r_out_z,  n_out_z;

    // Datapath wires
    t_mul_a mul_a;
    t_mul_b mul_b;
    t_prod  mul_p;
    t_wide  sc_w;
    t_wide  da_sat;
    t_wide  az_sum;
    t_wide  el_sum;
    t_az    ang_sel;
    t_trig  z_conv;
    t_trig  cx_shift;
    t_trig  cy_shift;
    t_trig  c_atan;
    t_trig  c_x;
    t_trig  c_y;
    t_trig  c_z;

    // Handshake ports
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.pos_x = r_out_x;
    assign o_out.pos_y = r_out_y;
    assign o_out.pos_z = r_out_z;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_A: begin
                mul_a = t_mul_a'(r_din_a);
                mul_b = t_mul_b'(r_sens);
            end
            S_MUL_E: begin
                mul_a = t_mul_a'(r_din_e);
                mul_b = t_mul_b'(r_sens);
            end
            S_MUL_B: begin
                mul_a = r_ce;
                mul_b = t_mul_b'(r_radius);
            end
            S_MUL_Y: begin
                mul_a = r_se;
                mul_b = t_mul_b'(r_radius);
            end
            S_MUL_XL: begin
                mul_a = r_sa;
                mul_b = {1'b0, r_base[SPLIT-1:0]};
            end
            S_MUL_XH: begin
                mul_a = r_sa;
                mul_b = {r_base[BASE_W-1], r_base[BASE_W-1:SPLIT]};
            end
            S_MUL_ZL: begin
                mul_a = r_ca;
                mul_b = {1'b0, r_base[SPLIT-1:0]};
            end
            S_MUL_ZH: begin
                mul_a = r_ca;
                mul_b = {r_base[BASE_W-1], r_base[BASE_W-1:SPLIT]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Delta scaling: round to nearest, ties up
    assign sc_w = t_wide'((r_prod + RND8) >>> 8);

    // Azimuth: saturate the delta, add, wrap once
    always_comb begin
        if (sc_w > LIM_AZ_W) begin
            da_sat = LIM_AZ_W;
        end else if (sc_w < -LIM_AZ_W) begin
            da_sat = -LIM_AZ_W;
        end else begin
            da_sat = sc_w;
        end
        az_sum = t_wide'(r_az) + da_sat;
        if (az_sum > LIM_AZ_W) begin
            az_sum = az_sum - LIM_AZ_W;
        end else if (az_sum < -LIM_AZ_W) begin
            az_sum = az_sum + LIM_AZ_W;
        end
    end

    // Elevation: add and clamp
    always_comb begin
        el_sum = t_wide'(r_el) + sc_w;
        if (el_sum > LIM_EL_W) begin
            el_sum = LIM_EL_W;
        end else if (el_sum < -LIM_EL_W) begin
            el_sum = -LIM_EL_W;
        end
    end

    // Angle to 2^-20 degree units
    assign ang_sel = r_sel_el ? t_az'(r_el) : r_az;
    assign z_conv  = t_trig'(ang_sel) <<< ZSH;

    // One CORDIC rotation step
    assign cx_shift = r_y >>> r_iter;
    assign cy_shift = r_x >>> r_iter;
    assign c_atan   = ATAN_TAB[TAB_IDX_W'(r_iter)];
    always_comb begin
        if (r_z >= 0) begin
            c_x = r_x - cx_shift;
            c_y = r_y + cy_shift;
            c_z = r_z - c_atan;
        end else begin
            c_x = r_x + cx_shift;
            c_y = r_y - cy_shift;
            c_z = r_z + c_atan;
        end
    end

    // Sequencer and next values
    always_comb begin
        n_state     = r_state;
        n_sens      = r_sens;
        n_radius    = r_radius;
        n_az        = r_az;
        n_el        = r_el;
        n_out_valid = r_out_valid && !o_out.ready;
        n_sel_el    = r_sel_el;
        n_iter      = r_iter;
        n_din_a     = r_din_a;
        n_din_e     = r_din_e;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_neg       = r_neg;
        n_sa        = r_sa;
        n_ca        = r_ca;
        n_se        = r_se;
        n_ce        = r_ce;
        n_base      = r_base;
        n_acc       = r_acc;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;

        // Register writes
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SENSITIVITY:  n_sens   = i_cfg.data[SENS_W-1:0];
                CFG_ORBIT_RADIUS: n_radius = i_cfg.data[RADIUS_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_din_a = i_in.delta_azimuth;
                    n_din_e = i_in.delta_elevation;
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: n_state = S_MUL_E;
            S_MUL_E: begin
                n_az    = t_az'(az_sum);
                n_state = S_UPD_E;
            end
            S_UPD_E: begin
                n_el     = t_el'(el_sum);
                n_sel_el = 1'b0;
                n_state  = S_WRAP;
            end
            S_WRAP: begin
                if (z_conv > ANG_HALF) begin
                    n_z = z_conv - ANG_FULL;
                end else if (z_conv < -ANG_HALF) begin
                    n_z = z_conv + ANG_FULL;
                end else begin
                    n_z = z_conv;
                end
                n_state = S_FOLD;
            end
            S_FOLD: begin
                // Fold into +-90 degrees, cosine sign flips
                if (r_z > ANG_QUARTER) begin
                    n_z   = ANG_HALF - r_z;
                    n_neg = 1'b1;
                end else if (r_z < -ANG_QUARTER) begin
                    n_z   = -ANG_HALF - r_z;
                    n_neg = 1'b1;
                end else begin
                    n_neg = 1'b0;
                end
                n_x     = CORDIC_K;
                n_y     = '0;
                n_iter  = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                n_x    = c_x;
                n_y    = c_y;
                n_z    = c_z;
                n_iter = r_iter + t_iter'(1);
                if (r_iter == IT_LAST) begin
                    if (!r_sel_el) begin
                        n_sa     = c_y;
                        n_ca     = r_neg ? -c_x : c_x;
                        n_sel_el = 1'b1;
                        n_state  = S_WRAP;
                    end else begin
                        n_se    = c_y;
                        n_ce    = r_neg ? -c_x : c_x;
                        n_state = S_MUL_B;
                    end
                end
            end
            S_MUL_B: n_state = S_MUL_Y;
            S_MUL_Y: begin
                n_base  = t_base'((r_prod + RND14) >>> 14);
                n_state = S_MUL_XL;
            end
            S_MUL_XL: begin
                n_py    = sat_pos((r_prod + RND30) >>> 30);
                n_state = S_MUL_XH;
            end
            S_MUL_XH: begin
                n_acc   = t_acc'((r_prod + RND45) >>> SPLIT);
                n_state = S_MUL_ZL;
            end
            S_MUL_ZL: begin
                n_px    = sat_pos((r_prod + t_prod'(r_acc)) >>> 29);
                n_state = S_MUL_ZH;
            end
            S_MUL_ZH: begin
                n_acc   = t_acc'((r_prod + RND45) >>> SPLIT);
                n_state = S_FIN_Z;
            end
            S_FIN_Z: begin
                n_pz    = sat_pos((r_prod + t_prod'(r_acc)) >>> 29);
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand off once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_x     = r_px;
                    n_out_y     = r_py;
                    n_out_z     = r_pz;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sens      <= SENS_RESET;
            r_radius    <= RADIUS_RESET;
            r_az        <= AZ_RESET;
            r_el        <= EL_RESET;
            r_out_valid <= 1'b0;
            r_sel_el    <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state     <= n_state;
            r_sens      <= n_sens;
            r_radius    <= n_radius;
            r_az        <= n_az;
            r_el        <= n_el;
            r_out_valid <= n_out_valid;
            r_sel_el    <= n_sel_el;
            r_iter      <= n_iter;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_din_a <= n_din_a;
        r_din_e <= n_din_e;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_neg   <= n_neg;
        r_sa    <= n_sa;
        r_ca    <= n_ca;
        r_se    <= n_se;
        r_ce    <= n_ce;
        r_prod  <= mul_p;
        r_base  <= n_base;
        r_acc   <= n_acc;
        r_px    <= n_px;
        r_py    <= n_py;
        r_pz    <= n_pz;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
        r_out_z <= n_out_z;
    end

    // Checks
    `ASSERT_NEXT(a_accept_starts, i_in.valid && i_in.ready, r_state == S_MUL_A, "accepted item did not start the sequence")
    `ASSERT_ALWAYS(a_az_range, (t_wide'(r_az) <= LIM_AZ_W) && (t_wide'(r_az) >= -LIM_AZ_W), "azimuth out of range")
    `ASSERT_ALWAYS(a_el_range, (t_wide'(r_el) <= LIM_EL_W) && (t_wide'(r_el) >= -LIM_EL_W), "elevation out of range")
    `ASSERT_NEXT(a_result_waits, (r_state == S_DONE) && r_out_valid && !o_out.ready, r_state == S_DONE, "result overwrote a pending item")

endmodule
